FILE: hdl/rpd_pkg.sv
// shared constants and helpers for the run-length pixel decoder
package rpd_pkg;

  // width of the remaining-pixel and run counters
  localparam int PIX_BITS = 24;

  // command codes on the input channel
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;
  localparam logic [1:0] ST_COMPLETE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_COLOR_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // color modes
  localparam logic [1:0] MODE_IDX8  = 2'd0;
  localparam logic [1:0] MODE_RGB16 = 2'd1;
  localparam logic [1:0] MODE_RGB24 = 2'd2;
  localparam logic [1:0] MODE_RGB32 = 2'd3;

  // record field phases
  localparam logic PHASE_COUNT = 1'b0;
  localparam logic PHASE_COLOR = 1'b1;

  // decoded pixel channels
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pixel_t;

  // bytes per count or color field for a mode
  function automatic logic [2:0] field_len(input logic [1:0] mode);
    case (mode)
      MODE_IDX8:  field_len = 3'd1;
      MODE_RGB16: field_len = 3'd2;
      default:    field_len = 3'd4;
    endcase
  endfunction

  // expand the packed color word to 8-bit channels
  function automatic pixel_t expand_color(input logic [1:0] mode, input logic [31:0] color);
    pixel_t px;
    case (mode)
      MODE_IDX8: begin
        px = '{blue: color[7:0], green: 8'h00, red: 8'h00, alpha: 8'h00};
      end
      MODE_RGB16: begin
        px.blue  = {color[4:0], 3'b000};
        px.green = {color[9:8], color[7:5], 3'b000};
        px.red   = {color[14:10], 3'b000};
        px.alpha = {8{color[15]}};
      end
      MODE_RGB24: begin
        px = '{blue: color[7:0], green: color[15:8], red: color[23:16], alpha: 8'hFF};
      end
      default: begin
        px = '{blue: color[7:0], green: color[15:8], red: color[23:16],
               alpha: color[31:24]};
      end
    endcase
    return px;
  endfunction

endpackage

FILE: hdl/rle_pixel_run_decoder.sv
// run-length pixel decoder: byte stream in, one status or pixel result per item
//
// in_cmd/in_data_byte arrive on a valid/ready channel. Stream bytes build a
// little-endian count field and then a color field, 1, 2 or 4 bytes each
// depending on color_mode. Tick items emit the pending run one pixel per tick;
// restart loads width*height as the number of pixels still owed.
// Every accepted item gives exactly one result on the out_ channel.
// The result of an item accepted at a clock edge is registered and valid
// right after that edge. Throughput is one item per cycle; the single output
// register sets it, and a new item is taken whenever that register is empty
// or is being drained in the same cycle.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken.
// Configuration writes on the cfg_ channel are always ready and take effect at
// once; they are meant for idle periods.
// Reset (synchronous, active low) returns the decoder to the count field,
// clears all counters and the error flag, zeroes the registers, and leaves
// no result pending; the image then reads as complete.
module rle_pixel_run_decoder (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_pixel_valid,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic [7:0] out_alpha,
  output logic       out_last_pixel,
  output logic [1:0] out_status,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [11:0] cfg_data
);
  import rpd_pkg::*;

  localparam int CMP_BITS = (PIX_BITS > 24) ? PIX_BITS : 24;
  localparam logic [PIX_BITS-1:0] PIX_MAX = {PIX_BITS{1'b1}};

  // configuration registers
  logic [1:0]  color_mode_r;
  logic [11:0] image_width_r;
  logic [11:0] image_height_r;

  // decoder state
  logic                field_phase_r, field_phase_nxt;
  logic [1:0]          byte_index_r, byte_index_nxt;
  logic [31:0]         count_accum_r, count_accum_nxt;
  logic [31:0]         color_accum_r, color_accum_nxt;
  logic [PIX_BITS-1:0] run_left_r, run_left_nxt;
  logic [PIX_BITS-1:0] pixels_left_r, pixels_left_nxt;
  logic                error_flag_r, error_flag_nxt;

  // output register
  logic       out_valid_r;
  logic       out_pixel_valid_r, out_pixel_valid_nxt;
  pixel_t     out_pixel_r, out_pixel_nxt;
  logic       out_last_pixel_r, out_last_pixel_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  logic        in_xfer;
  logic [2:0]  flen;
  logic        field_done;
  logic [4:0]  shamt;
  logic [31:0] byte_word;
  logic [31:0] count_merged;
  logic [31:0] color_merged;
  logic [23:0] area;
  logic [CMP_BITS-1:0] area_ext;
  logic [PIX_BITS-1:0] area_sat;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // field bookkeeping shared by count and color bytes
  assign flen         = field_len(color_mode_r);
  assign field_done   = ({1'b0, byte_index_r} + 3'd1) >= flen;
  assign shamt        = {byte_index_r, 3'b000};
  assign byte_word    = 32'(in_data_byte) << shamt;
  assign count_merged = ((byte_index_r == 2'd0) ? 32'd0 : count_accum_r) | byte_word;
  assign color_merged = ((byte_index_r == 2'd0) ? 32'd0 : color_accum_r) | byte_word;

  // pixel total for restart, saturated to the counter width
  assign area     = 24'(image_width_r) * 24'(image_height_r);
  assign area_ext = CMP_BITS'(area);
  assign area_sat = (area_ext > CMP_BITS'(PIX_MAX)) ? PIX_MAX : PIX_BITS'(area);

  // next state and result for the item on the input port
  always_comb begin
    field_phase_nxt     = field_phase_r;
    byte_index_nxt      = byte_index_r;
    count_accum_nxt     = count_accum_r;
    color_accum_nxt     = color_accum_r;
    run_left_nxt        = run_left_r;
    pixels_left_nxt     = pixels_left_r;
    error_flag_nxt      = error_flag_r;
    out_pixel_valid_nxt = 1'b0;
    out_pixel_nxt       = '0;
    out_last_pixel_nxt  = 1'b0;
    out_status_nxt      = ST_OK;
    case (in_cmd)
      CMD_RESTART: begin
        pixels_left_nxt = area_sat;
        field_phase_nxt = PHASE_COUNT;
        byte_index_nxt  = 2'd0;
        count_accum_nxt = 32'd0;
        color_accum_nxt = 32'd0;
        run_left_nxt    = '0;
        error_flag_nxt  = 1'b0;
      end
      CMD_BYTE: begin
        if (error_flag_r) begin
          out_status_nxt = ST_OVERRUN;
        end else if (run_left_r != '0) begin
          out_status_nxt = ST_REJECT;
        end else if (pixels_left_r == '0) begin
          out_status_nxt = ST_COMPLETE;
        end else if (field_phase_r == PHASE_COUNT) begin
          count_accum_nxt = count_merged;
          if (field_done) begin
            field_phase_nxt = PHASE_COLOR;
            byte_index_nxt  = 2'd0;
          end else begin
            byte_index_nxt = byte_index_r + 2'd1;
          end
        end else begin
          color_accum_nxt = color_merged;
          if (field_done) begin
            field_phase_nxt = PHASE_COUNT;
            byte_index_nxt  = 2'd0;
            // run must fit in the pixels still owed
            if (count_accum_r > 32'(pixels_left_r)) begin
              error_flag_nxt = 1'b1;
              out_status_nxt = ST_OVERRUN;
            end else begin
              run_left_nxt = PIX_BITS'(count_accum_r);
            end
          end else begin
            byte_index_nxt = byte_index_r + 2'd1;
          end
        end
      end
      CMD_TICK: begin
        if (error_flag_r) begin
          out_status_nxt = ST_OVERRUN;
        end else if (run_left_r == '0) begin
          out_status_nxt = (pixels_left_r == '0) ? ST_COMPLETE : ST_REJECT;
        end else begin
          run_left_nxt        = run_left_r - PIX_BITS'(1);
          pixels_left_nxt     = pixels_left_r - PIX_BITS'(1);
          out_pixel_valid_nxt = 1'b1;
          out_pixel_nxt       = expand_color(color_mode_r, color_accum_r);
          out_last_pixel_nxt  = (pixels_left_r == PIX_BITS'(1));
        end
      end
      default: begin
        out_status_nxt = ST_REJECT;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= MODE_IDX8;
      image_width_r  <= '0;
      image_height_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLOR_MODE:   color_mode_r   <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // decoder state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_phase_r <= PHASE_COUNT;
      byte_index_r  <= 2'd0;
      count_accum_r <= 32'd0;
      color_accum_r <= 32'd0;
      run_left_r    <= '0;
      pixels_left_r <= '0;
      error_flag_r  <= 1'b0;
    end else if (in_xfer) begin
      field_phase_r <= field_phase_nxt;
      byte_index_r  <= byte_index_nxt;
      count_accum_r <= count_accum_nxt;
      color_accum_r <= color_accum_nxt;
      run_left_r    <= run_left_nxt;
      pixels_left_r <= pixels_left_nxt;
      error_flag_r  <= error_flag_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_pixel_valid_r <= out_pixel_valid_nxt;
      out_pixel_r       <= out_pixel_nxt;
      out_last_pixel_r  <= out_last_pixel_nxt;
      out_status_r      <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pixel_valid_r;
  assign out_blue        = out_pixel_r.blue;
  assign out_green       = out_pixel_r.green;
  assign out_red         = out_pixel_r.red;
  assign out_alpha       = out_pixel_r.alpha;
  assign out_last_pixel  = out_last_pixel_r;
  assign out_status      = out_status_r;

  // a pending run never exceeds the pixels still owed
  a_run_within_image: assert property (@(posedge clk) disable iff (!rst_n)
    run_left_r <= pixels_left_r)
    else $error("run_left exceeds pixels_left");

  // an overrun leaves no run pending
  a_error_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    error_flag_r |-> run_left_r == '0)
    else $error("run pending with error latched");

  // a pixel result always carries ok status
  a_pixel_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pixel_valid_r |-> out_status_r == ST_OK)
    else $error("pixel result with non-ok status");

  // last pixel flag only on a pixel result
  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_pixel_r |-> out_pixel_valid_r)
    else $error("last_pixel without pixel");

  // every input transfer leaves a result in the output register
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("input transfer without result");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the run-length pixel decoder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  // cmd code that the decoder must reject
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 80;
  localparam logic [31:0] PIX_MAX = 32'((64'd1 << PIX_BITS) - 64'd1);

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } stream_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last_pixel;
    logic [1:0] status;
  } run_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = CMD_BYTE;
  logic [7:0] in_data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_pixel_valid;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;
  logic out_last_pixel;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_COLOR_MODE;
  logic [11:0] cfg_data = 12'h000;

  // stimulus and expectation stores
  stream_item_t stream_items[$];
  run_result_t predicted_pixels[$];
  stream_item_t next_item;
  run_result_t oldest_pixel;
  int items_queued = 0;
  int items_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // idling controls, written by the sequencer and the receiver at clock edges
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_armed = 1'b0;
  int hold_left = 0;

  // predictor copy of the registers
  logic [1:0] mode_cfg = MODE_IDX8;
  logic [11:0] width_cfg = 12'd0;
  logic [11:0] height_cfg = 12'd0;

  // predictor copy of the decoder state
  logic phase_m;
  logic [1:0] byte_idx_m;
  logic [31:0] count_acc_m;
  logic [31:0] color_acc_m;
  logic [PIX_BITS-1:0] run_left_m;
  logic [PIX_BITS-1:0] pixels_left_m;
  logic err_latched_m;

  rle_pixel_run_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_valid(out_pixel_valid),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_alpha      (out_alpha),
    .out_last_pixel (out_last_pixel),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5ns clk = ~clk;

  // bytes per count or color field
  function automatic logic [2:0] field_bytes(input logic [1:0] mode);
    case (mode)
      MODE_IDX8:  return 3'd1;
      MODE_RGB16: return 3'd2;
      default:    return 3'd4;
    endcase
  endfunction

  // advance the predicted decoder by one item and store the expected result
  task automatic decode_item(input logic [1:0] cmd, input logic [7:0] data);
    run_result_t res;
    logic [2:0] flen;
    logic [31:0] shifted;
    logic [63:0] total;
    logic [7:0] c0, c1, c2, c3;
    res = '0;
    flen = field_bytes(mode_cfg);
    shifted = {24'h0, data} << (byte_idx_m * 8);
    if (cmd == CMD_RESTART) begin
      total = {52'h0, width_cfg} * {52'h0, height_cfg};
      pixels_left_m = (total > {32'h0, PIX_MAX}) ? PIX_MAX[PIX_BITS-1:0] : total[PIX_BITS-1:0];
      phase_m = PHASE_COUNT;
      byte_idx_m = 2'd0;
      count_acc_m = 32'h0;
      color_acc_m = 32'h0;
      run_left_m = '0;
      err_latched_m = 1'b0;
      res.status = ST_OK;
    end else if (cmd == CMD_UNKNOWN) begin
      res.status = ST_REJECT;
    end else if (err_latched_m) begin
      res.status = ST_OVERRUN;
    end else if (cmd == CMD_BYTE) begin
      if (run_left_m != 0) begin
        res.status = ST_REJECT;
      end else if (pixels_left_m == 0) begin
        res.status = ST_COMPLETE;
      end else if (phase_m == PHASE_COUNT) begin
        if (byte_idx_m == 2'd0) count_acc_m = 32'h0;
        count_acc_m |= shifted;
        if ({1'b0, byte_idx_m} + 3'd1 >= flen) begin
          phase_m = PHASE_COLOR;
          byte_idx_m = 2'd0;
        end else begin
          byte_idx_m = byte_idx_m + 2'd1;
        end
        res.status = ST_OK;
      end else begin
        if (byte_idx_m == 2'd0) color_acc_m = 32'h0;
        color_acc_m |= shifted;
        res.status = ST_OK;
        if ({1'b0, byte_idx_m} + 3'd1 >= flen) begin
          phase_m = PHASE_COUNT;
          byte_idx_m = 2'd0;
          // record complete: check the run against the pixels still owed
          if (count_acc_m > 32'(pixels_left_m)) begin
            err_latched_m = 1'b1;
            res.status = ST_OVERRUN;
          end else begin
            run_left_m = count_acc_m[PIX_BITS-1:0];
          end
        end else begin
          byte_idx_m = byte_idx_m + 2'd1;
        end
      end
    end else if (run_left_m == 0) begin
      // tick with nothing pending
      res.status = (pixels_left_m == 0) ? ST_COMPLETE : ST_REJECT;
    end else begin
      c0 = color_acc_m[7:0];
      c1 = color_acc_m[15:8];
      c2 = color_acc_m[23:16];
      c3 = color_acc_m[31:24];
      case (mode_cfg)
        MODE_IDX8: begin
          res.blue = c0;
        end
        MODE_RGB16: begin
          res.blue  = {c0[4:0], 3'b000};
          res.green = {c1[1:0], c0[7:5], 3'b000};
          res.red   = {c1[6:2], 3'b000};
          res.alpha = {8{c1[7]}};
        end
        MODE_RGB24: begin
          res.blue  = c0;
          res.green = c1;
          res.red   = c2;
          res.alpha = 8'hFF;
        end
        default: begin
          res.blue  = c0;
          res.green = c1;
          res.red   = c2;
          res.alpha = c3;
        end
      endcase
      run_left_m = run_left_m - 1'b1;
      pixels_left_m = pixels_left_m - 1'b1;
      res.pixel_valid = 1'b1;
      res.last_pixel = (pixels_left_m == 0);
      res.status = ST_OK;
    end
    predicted_pixels.push_back(res);
  endtask

  // input driver: offers queued items, predicts each accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      phase_m = PHASE_COUNT;
      byte_idx_m = 2'd0;
      count_acc_m = 32'h0;
      color_acc_m = 32'h0;
      run_left_m = '0;
      pixels_left_m = '0;
      err_latched_m = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_item(in_cmd, in_data_byte);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (stream_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_item = stream_items.pop_front();
          in_valid <= 1'b1;
          in_cmd <= next_item.cmd;
          in_data_byte <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_armed <= 1'b0;
    end else if (hold_req && !hold_armed) begin
      hold_left <= LONG_HOLD;
      hold_armed <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      hold_armed <= hold_req;
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_pixels.size() == 0) begin
        $error("result with no prediction waiting, status %0d", out_status);
        mismatch_count++;
      end else begin
        oldest_pixel = predicted_pixels.pop_front();
        check_field("pixel_valid", 8'(oldest_pixel.pixel_valid), 8'(out_pixel_valid));
        check_field("blue", oldest_pixel.blue, out_blue);
        check_field("green", oldest_pixel.green, out_green);
        check_field("red", oldest_pixel.red, out_red);
        check_field("alpha", oldest_pixel.alpha, out_alpha);
        check_field("last_pixel", 8'(oldest_pixel.last_pixel), 8'(out_last_pixel));
        check_field("status", 8'(oldest_pixel.status), 8'(out_status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rle_pixel_run_decoder: mismatch");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] data);
    stream_items.push_back('{cmd: cmd, data: data});
    items_queued++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(CMD_TICK, 8'($urandom));
  endtask

  // one well-formed record at the current field length
  task automatic push_record(input logic [31:0] run_len, input logic [31:0] color);
    logic [2:0] flen;
    flen = field_bytes(mode_cfg);
    for (int i = 0; i < flen; i++) push_item(CMD_BYTE, run_len[8*i +: 8]);
    for (int i = 0; i < flen; i++) push_item(CMD_BYTE, color[8*i +: 8]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COLOR_MODE:  mode_cfg = value[1:0];
      REG_IMAGE_WIDTH: width_cfg = value;
      default:         height_cfg = value;
    endcase
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    @(posedge clk);
    tx_idle_pct <= tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // sender pause: every queued item taken and every result back
  task automatic drain();
    @(posedge clk);
    while (items_taken != items_queued || predicted_pixels.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed records with random content, plus noise
  task automatic gen_random_stream(input int n_items);
    int start;
    int pick;
    logic [31:0] run_len;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        pick = $urandom_range(99);
        if (pick < 75) run_len = $urandom_range(4, 0);
        else if (pick < 92) run_len = $urandom_range(12, 5);
        else run_len = $urandom;
        push_record(run_len, $urandom);
        push_ticks(((run_len > 12) ? 12 : int'(run_len)) + $urandom_range(1, 0));
      end else if (pick < 68) begin
        push_item(CMD_TICK, 8'($urandom));
      end else if (pick < 80) begin
        push_item(CMD_BYTE, 8'($urandom));
      end else if (pick < 85) begin
        push_item(CMD_RESTART, 8'($urandom));
      end else if (pick < 89) begin
        push_item(CMD_UNKNOWN, 8'($urandom));
      end else begin
        // broken record: a few stray bytes
        repeat ($urandom_range(3, 1)) push_item(CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  // sequencer
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty image after reset: everything but the restart completes or is rejected
    push_item(CMD_TICK, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_UNKNOWN, 8'hFF);
    push_item(CMD_RESTART, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    drain();

    // largest image, oversized run latches the error
    write_reg(REG_COLOR_MODE, 12'(MODE_RGB32));
    write_reg(REG_IMAGE_WIDTH, 12'd4095);
    write_reg(REG_IMAGE_HEIGHT, 12'd4095);
    push_item(CMD_RESTART, 8'hFF);
    push_record(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_TICK, 8'h00);
    drain();

    // zero-length run, byte while run pending, last pixel, then complete
    write_reg(REG_COLOR_MODE, 12'(MODE_IDX8));
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd1);
    push_item(CMD_RESTART, 8'h00);
    push_record(32'd0, 32'h00);
    push_record(32'd3, 32'hFF);
    push_item(CMD_BYTE, 8'h80);
    push_ticks(4);
    drain();

    // mode switched in the middle of a count field and of a run
    write_reg(REG_COLOR_MODE, 12'(MODE_RGB32));
    write_reg(REG_IMAGE_WIDTH, 12'd2);
    write_reg(REG_IMAGE_HEIGHT, 12'd2);
    push_item(CMD_RESTART, 8'h00);
    push_item(CMD_BYTE, 8'h01);
    push_item(CMD_BYTE, 8'h00);
    drain();
    write_reg(REG_COLOR_MODE, 12'(MODE_IDX8));
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hDA);
    drain();
    write_reg(REG_COLOR_MODE, 12'(MODE_RGB16));
    push_item(CMD_TICK, 8'h00);
    drain();

    // random phases across the idling patterns
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: set_idle(0, 0);
        1: set_idle(54, 0);
        2: set_idle(0, 54);
        default: set_idle(21, 21);
      endcase
      write_reg(REG_COLOR_MODE, 12'($urandom_range(3, 0)));
      write_reg(REG_IMAGE_WIDTH, (ph == 3) ? 12'd4095 : 12'($urandom_range(6, 0)));
      write_reg(REG_IMAGE_HEIGHT, (ph == 3) ? 12'd4095 : 12'($urandom_range(5, 1)));
      // sometimes keep the old record or run going across the mode change
      if ($urandom_range(2, 0) != 0) push_item(CMD_RESTART, 8'($urandom));
      gen_random_stream(30);
      drain();
    end

    // long receiver hold-off while the sender keeps offering
    set_idle(0, 0);
    write_reg(REG_COLOR_MODE, 12'(MODE_RGB24));
    write_reg(REG_IMAGE_WIDTH, 12'd5);
    write_reg(REG_IMAGE_HEIGHT, 12'd4);
    @(posedge clk);
    hold_req <= 1'b1;
    push_item(CMD_RESTART, 8'h00);
    gen_random_stream(40);
    drain();
    @(posedge clk);
    hold_req <= 1'b0;

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rle_pixel_run_decoder: match");
    end else begin
      $display("rle_pixel_run_decoder: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rpd_pkg.sv
hdl/rle_pixel_run_decoder.sv
tb/tb.sv
